@@ sv/assert_macros.svh @@
// Assertion helpers for the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define BBA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bitmap allocator assertion failed");

// Expression must never be true at a clock edge outside reset.
`define BBA_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("bitmap allocator forbidden condition seen");

`else

`define BBA_ASSERT(lbl, clk, rst_n, prop)
`define BBA_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

@@ sv/bba_pkg.sv @@
package bba_pkg;

    // Bitmap geometry; WORD_BITS is a power of two.
    localparam int MAP_BITS    = 8192;
    localparam int WORD_BITS   = 64;
    localparam int MAP_WORDS   = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_IDX_W  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_IDX_W   = $clog2(WORD_BITS);
    localparam int MAP_IDX_W   = WORD_IDX_W + BIT_IDX_W;

    localparam int BLK_W       = 32;
    localparam int CFG_IDX_W   = 1;

    localparam logic [BLK_W-1:0] LIMIT_RESET = 32'd8192;

    // Request kinds
    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BLOCK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LIMIT = 1'b1;

    typedef logic [WORD_BITS-1:0]  map_word_t;
    typedef logic [WORD_IDX_W-1:0] word_idx_t;
    typedef logic [BIT_IDX_W-1:0]  bit_idx_t;

    typedef struct packed {
        logic      rd_en;
        word_idx_t rd_addr;
        logic      wr_en;
        word_idx_t wr_addr;
    } map_cmd_t;

    typedef struct packed {
        logic     found;
        bit_idx_t bit_idx;
    } scan_res_t;

endpackage

@@ sv/bitmap_block_allocator.sv @@
// Channel   Handshake          Payload                              Dir
// -------   ---------          -------                              ---
// request   start / busy       req_type, block_number               in
// result    done (strobe)      status, alloc_block, block_free      out
// config    cfg_we             cfg_index, cfg_data                  in
//
// A request is taken at an edge with start high and busy low; busy stays
// high until the result edge. Allocate walks the bitmap one 64-bit word per
// cycle through the single word scanner and the one read port of the map
// store; a hit returns its block, and a full map answers after the last word.
// An in-range free or query runs a range check, a word read, then an update
// or answer; an out-of-range block or the unused request kind answers right
// after the range check.
// Reset (rst_n, async low) marks every block free through per-row valid
// bits; no clearing pass is needed. done is high for one cycle and cannot
// be held off; the next request may be taken in that same cycle.
module bitmap_block_allocator
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        req_type,
    input  logic [bba_pkg::BLK_W-1:0]         block_number,
    output logic                              done,
    output logic [1:0]                        status,
    output logic [bba_pkg::BLK_W-1:0]         alloc_block,
    output logic                              block_free,
    input  logic                              cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bba_pkg::BLK_W-1:0]         cfg_data
);

`include "assert_macros.svh"

    // Sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_FETCH = 2'd2;
    localparam logic [1:0] S_SCAN  = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [1:0]                   req_reg, req_next;
    logic [bba_pkg::BLK_W-1:0]    blk_reg, blk_next;
    bba_pkg::word_idx_t           word_reg, word_next;
    bba_pkg::bit_idx_t            bit_sel_reg, bit_sel_next;
    logic [bba_pkg::BLK_W:0]      base_reg, base_next;

    logic [bba_pkg::BLK_W-1:0]    first_block_reg;
    logic [bba_pkg::BLK_W-1:0]    block_limit_reg;

    logic                         done_reg, done_next;
    logic [1:0]                   status_reg, status_next;
    logic [bba_pkg::BLK_W-1:0]    alloc_block_reg, alloc_block_next;
    logic                         block_free_reg, block_free_next;

    bba_pkg::map_cmd_t            map_cmd;
    bba_pkg::map_word_t           map_wr_data;
    bba_pkg::map_word_t           map_rd_data;
    bba_pkg::scan_res_t           scan_res;

    logic [bba_pkg::BLK_W-1:0]    offset;
    logic                         in_range;
    logic                         accept;

    // Word store shared by all request kinds, and word scanner for allocate
    bba_map_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (map_cmd),
        .wr_data (map_wr_data),
        .rd_data (map_rd_data)
    );

    bba_word_scan u_scan
    (
        .word     (map_rd_data),
        .word_idx (word_reg),
        .base     (base_reg),
        .limit    (block_limit_reg),
        .res      (scan_res)
    );

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    // Range rule for free and query: first <= b < limit, inside the map
    assign offset   = blk_reg - first_block_reg;
    assign in_range = (blk_reg >= first_block_reg)
                      && (blk_reg < block_limit_reg)
                      && (offset < bba_pkg::BLK_W'(bba_pkg::MAP_BITS));

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_block_reg <= '0;
            block_limit_reg <= bba_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bba_pkg::CFG_FIRST_BLOCK: first_block_reg <= cfg_data;
                bba_pkg::CFG_BLOCK_LIMIT: block_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        blk_next         = blk_reg;
        word_next        = word_reg;
        bit_sel_next     = bit_sel_reg;
        base_next        = base_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        alloc_block_next = alloc_block_reg;
        block_free_next  = block_free_reg;
        map_cmd          = '0;
        map_wr_data      = map_rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next = req_type;
                    blk_next = block_number;
                    if (req_type == bba_pkg::REQ_ALLOC)
                    begin
                        // Fetch word zero; its scan runs next cycle
                        map_cmd.rd_en   = 1'b1;
                        map_cmd.rd_addr = '0;
                        word_next       = '0;
                        base_next       = {1'b0, first_block_reg};
                        state_next      = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end

            S_CHECK:
            begin
                if (req_reg != bba_pkg::REQ_FREE && req_reg != bba_pkg::REQ_QUERY)
                begin
                    // Unknown kind: plain ok, no change
                    done_next        = 1'b1;
                    status_next      = bba_pkg::ST_OK;
                    alloc_block_next = '0;
                    block_free_next  = 1'b0;
                    state_next       = S_IDLE;
                end
                else if (!in_range)
                begin
                    done_next        = 1'b1;
                    status_next      = bba_pkg::ST_RANGE;
                    alloc_block_next = '0;
                    block_free_next  = 1'b0;
                    state_next       = S_IDLE;
                end
                else
                begin
                    map_cmd.rd_en   = 1'b1;
                    map_cmd.rd_addr = offset[bba_pkg::MAP_IDX_W-1:bba_pkg::BIT_IDX_W];
                    word_next       = offset[bba_pkg::MAP_IDX_W-1:bba_pkg::BIT_IDX_W];
                    bit_sel_next    = offset[bba_pkg::BIT_IDX_W-1:0];
                    state_next      = S_FETCH;
                end
            end

            S_FETCH:
            begin
                done_next        = 1'b1;
                status_next      = bba_pkg::ST_OK;
                alloc_block_next = '0;
                if (req_reg == bba_pkg::REQ_FREE)
                begin
                    // Clear the bit and write the word back
                    map_cmd.wr_en   = 1'b1;
                    map_cmd.wr_addr = word_reg;
                    map_wr_data     = map_rd_data
                                      & ~(bba_pkg::WORD_BITS'(1) << bit_sel_reg);
                    block_free_next = 1'b0;
                end
                else
                begin
                    block_free_next = ~map_rd_data[bit_sel_reg];
                end
                state_next = S_IDLE;
            end

            S_SCAN:
            begin
                if (scan_res.found)
                begin
                    // Mark the hit used and grant it
                    map_cmd.wr_en    = 1'b1;
                    map_cmd.wr_addr  = word_reg;
                    map_wr_data      = map_rd_data
                                       | (bba_pkg::WORD_BITS'(1) << scan_res.bit_idx);
                    done_next        = 1'b1;
                    status_next      = bba_pkg::ST_OK;
                    alloc_block_next = base_reg[bba_pkg::BLK_W-1:0]
                                       + bba_pkg::BLK_W'(scan_res.bit_idx);
                    block_free_next  = 1'b0;
                    state_next       = S_IDLE;
                end
                else if (word_reg == bba_pkg::WORD_IDX_W'(bba_pkg::MAP_WORDS - 1))
                begin
                    done_next        = 1'b1;
                    status_next      = bba_pkg::ST_FULL;
                    alloc_block_next = '0;
                    block_free_next  = 1'b0;
                    state_next       = S_IDLE;
                end
                else
                begin
                    // Advance to the next word
                    map_cmd.rd_en   = 1'b1;
                    map_cmd.rd_addr = word_reg + 1'b1;
                    word_next       = word_reg + 1'b1;
                    base_next       = base_reg + (bba_pkg::BLK_W+1)'(bba_pkg::WORD_BITS);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        blk_reg         <= blk_next;
        word_reg        <= word_next;
        bit_sel_reg     <= bit_sel_next;
        base_reg        <= base_next;
        status_reg      <= status_next;
        alloc_block_reg <= alloc_block_next;
        block_free_reg  <= block_free_next;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign alloc_block = alloc_block_reg;
    assign block_free  = block_free_reg;

    // A result only ends a request that was in flight
    `BBA_ASSERT(a_done_after_busy, clk, rst_n, done |-> $past(busy))
    // Every accepted request holds the block busy for at least one cycle
    `BBA_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy)
    // Failed results carry no grant and no free flag
    `BBA_ASSERT(a_fail_clean, clk, rst_n,
        (done && status != bba_pkg::ST_OK) |-> (alloc_block == '0 && !block_free))
    // Read and write never target the same row in one cycle
    `BBA_ASSERT_NEVER(a_rw_clash, clk, rst_n,
        map_cmd.rd_en && map_cmd.wr_en && map_cmd.rd_addr == map_cmd.wr_addr)

endmodule

@@ sv/bba_map_store.sv @@
// Bitmap word store: one write and one registered read per cycle.
// Rows never written read as all free.
module bba_map_store
(
    input  logic                clk,
    input  logic                rst_n,
    input  bba_pkg::map_cmd_t   cmd,
    input  bba_pkg::map_word_t  wr_data,
    output bba_pkg::map_word_t  rd_data
);

    bba_pkg::map_word_t             mem [bba_pkg::MAP_WORDS];
    logic [bba_pkg::MAP_WORDS-1:0]  row_vld_reg;
    bba_pkg::map_word_t             rd_data_reg;
    logic                           rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                row_vld_reg[cmd.wr_addr] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_vld_reg <= row_vld_reg[cmd.rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

@@ sv/bba_word_scan.sv @@
// Find the lowest free bit of one bitmap word whose block lies below the
// limit and inside the map.
module bba_word_scan
(
    input  bba_pkg::map_word_t           word,
    input  bba_pkg::word_idx_t           word_idx,
    input  logic [bba_pkg::BLK_W:0]      base,
    input  logic [bba_pkg::BLK_W-1:0]    limit,
    output bba_pkg::scan_res_t           res
);

    logic [bba_pkg::BLK_W:0]      lim_ext;
    logic [bba_pkg::BLK_W:0]      room;
    logic                         has_room;
    logic                         full_word;
    bba_pkg::map_word_t           usable;
    bba_pkg::map_word_t           cand;
    logic [bba_pkg::MAP_IDX_W:0]  gidx [bba_pkg::WORD_BITS];

    assign lim_ext   = {1'b0, limit};
    assign has_room  = lim_ext > base;
    assign room      = lim_ext - base;
    assign full_word = room >= (bba_pkg::BLK_W+1)'(bba_pkg::WORD_BITS);

    always_comb
    begin
        for (int j = 0; j < bba_pkg::WORD_BITS; j++)
        begin
            gidx[j]   = {1'b0, word_idx, bba_pkg::BIT_IDX_W'(j)};
            usable[j] = has_room
                        && (full_word
                            || room[bba_pkg::BIT_IDX_W-1:0] > bba_pkg::BIT_IDX_W'(j))
                        && (gidx[j] < (bba_pkg::MAP_IDX_W+1)'(bba_pkg::MAP_BITS));
        end
    end

    assign cand = ~word & usable;

    always_comb
    begin
        res.found   = |cand;
        res.bit_idx = '0;
        for (int j = bba_pkg::WORD_BITS - 1; j >= 0; j--)
        begin
            if (cand[j])
            begin
                res.bit_idx = bba_pkg::BIT_IDX_W'(j);
            end
        end
    end

endmodule
